>>> src/met_pkg.sv
// ----------------------------------------------------------------------------
// met_pkg
// Shared types, constants and fixed-point helpers of the escape-time block.
// ----------------------------------------------------------------------------
package met_pkg;

  localparam int PIXEL_BITS = 12;
  localparam int ITER_LIMIT = 65536;
  localparam int FRAC_BITS  = 28;

  localparam int COORD_W = 32;                       // Q4.28 coordinate
  localparam int STEP_W  = 31;
  localparam int ITER_W  = 17;                       // iteration count field
  localparam int SQ_W    = 2 * COORD_W - FRAC_BITS;  // truncated product
  localparam int SAT_W   = 48;                       // headroom for saturation
  localparam int CPROD_W = PIXEL_BITS + STEP_W;      // pixel * step

  localparam int FIFO_DEPTH = 2;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_RE_ORIGIN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_REAL_STEP = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_IM_ORIGIN = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_IMAG_STEP = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = CFG_IDX_W'(4);

  localparam logic signed [COORD_W-1:0] RST_RE_ORIGIN = -32'sd536870912;
  localparam logic signed [COORD_W-1:0] RST_IM_ORIGIN = -32'sd536870912;
  localparam logic [STEP_W-1:0]         RST_STEP      = STEP_W'(1048576);
  localparam logic [ITER_W-1:0]         RST_MAX_ITER  = ITER_W'(65536);

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // escape radius squared, 4.0 in the fraction format
  localparam logic signed [SAT_W-1:0] FOUR = SAT_W'(4) <<< FRAC_BITS;

  typedef struct packed {
    logic signed [COORD_W-1:0] re_origin;
    logic [STEP_W-1:0]         real_step;
    logic signed [COORD_W-1:0] im_origin;
    logic [STEP_W-1:0]         imag_step;
    logic [ITER_W-1:0]         limit;      // already clamped to 1..ITER_LIMIT
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] cr;
    logic signed [COORD_W-1:0] ci;
  } point_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SAT_W-1:0] v);
    if (v > SAT_W'(COORD_MAX)) return COORD_MAX;
    if (v < SAT_W'(COORD_MIN)) return COORD_MIN;
    return v[COORD_W-1:0];
  endfunction

  function automatic logic [ITER_W-1:0] eff_limit(input logic [ITER_W-1:0] m);
    if (m == '0) return ITER_W'(1);
    if (m > ITER_W'(ITER_LIMIT)) return ITER_W'(ITER_LIMIT);
    return m;
  endfunction

endpackage

>>> src/met_if.sv
// ----------------------------------------------------------------------------
// met_if
// Valid/ready channels for pixel coordinates and iteration counts.
// ----------------------------------------------------------------------------
interface met_pix_if;
  import met_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_x;
  logic [PIXEL_BITS-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface met_res_if;
  import met_pkg::*;
  logic              valid;
  logic              ready;
  logic [ITER_W-1:0] iter_count;

  modport source (output valid, output iter_count, input ready);
  modport sink   (input valid, input iter_count, output ready);
endinterface

>>> src/met_front.sv
// ----------------------------------------------------------------------------
// met_front
// Maps a pixel index pair to the point c: multiply stage, then offset and
// saturate stage, then push into the point queue.
// ----------------------------------------------------------------------------
module met_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  met_pix_if.sink               pix,
  input  met_pkg::cfg_t         cfg_i,
  input  met_pkg::q_stat_t      q_stat_i,
  output logic                  push_o,
  output met_pkg::point_t       point_o
);
  import met_pkg::*;

  logic               s1_v_q;
  logic [CPROD_W-1:0] s1_pr_q, s1_pi_q;
  logic               s2_v_q;
  point_t             s2_pt_q;
  logic               s2_load, s1_adv, accept;
  point_t             pt_d;

  assign push_o  = s2_v_q && !q_stat_i.full;
  assign s2_load = !s2_v_q || push_o;
  assign s1_adv  = s1_v_q && s2_load;
  assign pix.ready = !s1_v_q || s1_adv;
  assign accept  = pix.valid && pix.ready;
  assign point_o = s2_pt_q;

  always_comb begin
    pt_d.cr = sat_coord(SAT_W'(cfg_i.re_origin) + SAT_W'($signed({1'b0, s1_pr_q})));
    pt_d.ci = sat_coord(SAT_W'(cfg_i.im_origin) + SAT_W'($signed({1'b0, s1_pi_q})));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (pix.ready) s1_v_q <= accept;
      if (s2_load)   s2_v_q <= s1_adv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pr_q <= CPROD_W'(pix.pixel_x) * CPROD_W'(cfg_i.real_step);
      s1_pi_q <= CPROD_W'(pix.pixel_y) * CPROD_W'(cfg_i.imag_step);
    end
    if (s1_adv) s2_pt_q <= pt_d;
  end

endmodule

>>> src/met_fifo.sv
// ----------------------------------------------------------------------------
// met_fifo
// Short point queue between the coordinate front end and the iterator.
// ----------------------------------------------------------------------------
module met_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  met_pkg::point_t   data_i,
  input  logic              pop_i,
  output met_pkg::point_t   data_o,
  output met_pkg::q_stat_t  stat_o
);
  import met_pkg::*;

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  point_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_q, rd_q;
  logic [CNT_W-1:0]   cnt_q;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(FIFO_DEPTH - 1)) return '0;
    return p + PTR_W'(1);
  endfunction

  assign stat_o.full  = (cnt_q == CNT_W'(FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign data_o       = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ptr_inc(wr_q);
      if (pop_i)  rd_q <= ptr_inc(rd_q);
      if (push_i && !pop_i)      cnt_q <= cnt_q + CNT_W'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

>>> src/met_back.sv
// ----------------------------------------------------------------------------
// met_back
// Escape-time iterator: squares z in its multiply state, checks the radius and
// forms z*z + c in the update state after it, and holds the count in an output register.
// ----------------------------------------------------------------------------
module met_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  met_pkg::cfg_t     cfg_i,
  input  met_pkg::point_t   point_i,
  input  met_pkg::q_stat_t  q_stat_i,
  output logic              pop_o,
  met_res_if.source         res
);
  import met_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_UPD, ST_DONE} state_e;

  state_e                    st_q;
  logic signed [COORD_W-1:0] cr_q, ci_q, zr_q, zi_q;
  logic signed [SQ_W-1:0]    rr_q, ii_q, ri_q;
  logic [ITER_W-1:0]         cnt_q;
  logic                      out_v_q;
  logic [ITER_W-1:0]         out_cnt_q;

  logic signed [2*COORD_W-1:0] p_rr, p_ii, p_ri;
  logic signed [COORD_W-1:0]   sr, si, zr_d, zi_d;
  logic signed [SAT_W-1:0]     norm;
  logic                        escaped, finished, out_free;

  assign pop_o      = (st_q == ST_IDLE) && !q_stat_i.empty;
  assign out_free   = !out_v_q || res.ready;
  assign res.valid      = out_v_q;
  assign res.iter_count = out_cnt_q;

  always_comb begin
    p_rr = (2*COORD_W)'(zr_q) * (2*COORD_W)'(zr_q);
    p_ii = (2*COORD_W)'(zi_q) * (2*COORD_W)'(zi_q);
    p_ri = (2*COORD_W)'(zr_q) * (2*COORD_W)'(zi_q);
    sr   = sat_coord(SAT_W'(rr_q) - SAT_W'(ii_q));
    si   = sat_coord(SAT_W'(ri_q) + SAT_W'(ri_q));
    zr_d = sat_coord(SAT_W'(sr) + SAT_W'(cr_q));
    zi_d = sat_coord(SAT_W'(si) + SAT_W'(ci_q));
    // squares of the current z double as its radius check
    norm     = SAT_W'(rr_q) + SAT_W'(ii_q);
    escaped  = (norm >= FOUR);
    finished = escaped || (cnt_q == cfg_i.limit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      out_v_q <= 1'b0;
    end else begin
      if (st_q == ST_DONE && out_free) begin
        out_v_q <= 1'b1;
      end else if (res.ready) begin
        out_v_q <= 1'b0;
      end
      unique case (st_q)
        ST_IDLE: begin
          if (pop_o) st_q <= ST_MUL;
        end
        ST_MUL: begin
          st_q <= ST_UPD;
        end
        ST_UPD: begin
          st_q <= finished ? ST_DONE : ST_MUL;
        end
        ST_DONE: begin
          if (out_free) st_q <= ST_IDLE;
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      ST_IDLE: begin
        if (pop_o) begin
          cr_q  <= point_i.cr;
          ci_q  <= point_i.ci;
          zr_q  <= '0;
          zi_q  <= '0;
          cnt_q <= '0;
        end
      end
      ST_MUL: begin
        rr_q <= p_rr[2*COORD_W-1:FRAC_BITS];
        ii_q <= p_ii[2*COORD_W-1:FRAC_BITS];
        ri_q <= p_ri[2*COORD_W-1:FRAC_BITS];
      end
      ST_UPD: begin
        if (!finished) begin
          zr_q  <= zr_d;
          zi_q  <= zi_d;
          cnt_q <= cnt_q + ITER_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) out_cnt_q <= cnt_q;
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_cnt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> out_cnt_q != '0)
    else $error("result count is zero");

  a_cnt_le_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != ST_IDLE) |-> cnt_q <= cfg_i.limit)
    else $error("iteration count passed the limit");

  a_start_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (st_q == ST_MUL && cnt_q == '0 && zr_q == '0 && zi_q == '0))
    else $error("new point did not start from z = 0");
`endif

endmodule

>>> src/mandelbrot_escape_time_top.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_top
// Mandelbrot escape-time counter with a register-programmed view window.
// ----------------------------------------------------------------------------
// Each pixel transaction yields one count transaction. The front end turns
// the pixel into c in its multiply and offset/saturate stages and queues
// it; the iterator takes a point when idle, runs a squaring step and a
// radius check and update step per iteration, one more such pair for the
// final radius check, and a step handing the count to the output register,
// so a point occupies it longer for a higher count (at most the clamped
// max_iter) and while its count waits on a stalled sink. The single squaring
// loop sets the rate; pixels for the next points are queued, while there is
// room, as the current one iterates or its count waits. The user must write
// configuration only while the block is idle; the block does not check it.
module mandelbrot_escape_time_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  met_pix_if.sink                           pix_i,
  met_res_if.source                         res_o,
  input  logic                              cfg_we_i,
  input  logic [met_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [met_pkg::COORD_W-1:0]       cfg_wdata_i
);
  import met_pkg::*;

  logic signed [COORD_W-1:0] re_origin_q, im_origin_q;
  logic [STEP_W-1:0]         real_step_q, imag_step_q;
  logic [ITER_W-1:0]         max_iter_q;

  cfg_t    cfg;
  q_stat_t q_stat;
  point_t  push_pt, pop_pt;
  logic    push, pop;

  always_comb begin
    cfg.re_origin = re_origin_q;
    cfg.real_step = real_step_q;
    cfg.im_origin = im_origin_q;
    cfg.imag_step = imag_step_q;
    cfg.limit     = eff_limit(max_iter_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      re_origin_q <= RST_RE_ORIGIN;
      real_step_q <= RST_STEP;
      im_origin_q <= RST_IM_ORIGIN;
      imag_step_q <= RST_STEP;
      max_iter_q  <= RST_MAX_ITER;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RE_ORIGIN: re_origin_q <= cfg_wdata_i;
        REG_REAL_STEP: real_step_q <= cfg_wdata_i[STEP_W-1:0];
        REG_IM_ORIGIN: im_origin_q <= cfg_wdata_i;
        REG_IMAG_STEP: imag_step_q <= cfg_wdata_i[STEP_W-1:0];
        REG_MAX_ITER:  max_iter_q  <= cfg_wdata_i[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  met_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pix      (pix_i),
    .cfg_i    (cfg),
    .q_stat_i (q_stat),
    .push_o   (push),
    .point_o  (push_pt)
  );

  met_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_pt),
    .pop_i  (pop),
    .data_o (pop_pt),
    .stat_o (q_stat)
  );

  met_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .point_i  (pop_pt),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .res      (res_o)
  );

endmodule

>>> dv/met_escape_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// met_escape_tb_pkg
// Iteration-count predictor and in-order scoreboard for the escape-time block.
// Keeps its own copy of the view window and limit. Every accepted pixel
// pushes the count it must produce, and every count transaction is checked
// against the oldest one.
// ----------------------------------------------------------------------------
package met_escape_tb_pkg;
  import met_pkg::*;

  class count_scoreboard;
    logic signed [COORD_W-1:0] re_origin;
    logic [STEP_W-1:0]         re_pitch;
    logic signed [COORD_W-1:0] im_origin;
    logic [STEP_W-1:0]         im_pitch;
    logic [ITER_W-1:0]         iter_cap;
    logic [ITER_W-1:0]         want_counts[$];
    bit                        limit_hit;
    int unsigned               n_pixels;
    int unsigned               n_checked;
    int unsigned               n_at_cap;
    int unsigned               n_errors;

    function new();
      re_origin = RST_RE_ORIGIN;
      re_pitch  = RST_STEP;
      im_origin = RST_IM_ORIGIN;
      im_pitch  = RST_STEP;
      iter_cap  = RST_MAX_ITER;
    endfunction

    // same register decode as the block; unused indexes fall through
    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] value);
      case (idx)
        REG_RE_ORIGIN: re_origin = value;
        REG_REAL_STEP: re_pitch  = value[STEP_W-1:0];
        REG_IM_ORIGIN: im_origin = value;
        REG_IMAG_STEP: im_pitch  = value[STEP_W-1:0];
        REG_MAX_ITER:  iter_cap  = value[ITER_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp_q(longint v);
      if (v > longint'(COORD_MAX)) return longint'(COORD_MAX);
      if (v < longint'(COORD_MIN)) return longint'(COORD_MIN);
      return v;
    endfunction

    // floor of the exact product, scaled back to the fraction format
    function longint qmul(longint a, longint b);
      return (a * b) >>> FRAC_BITS;
    endfunction

    function logic [ITER_W-1:0] escape_count(logic [PIXEL_BITS-1:0] px,
                                             logic [PIXEL_BITS-1:0] py);
      longint      cr, ci, zr, zi, sq_re, sq_im, radius2;
      int unsigned cap, n;
      bit          escaped;
      cr = clamp_q(longint'(re_origin) + longint'(px) * longint'(re_pitch));
      ci = clamp_q(longint'(im_origin) + longint'(py) * longint'(im_pitch));
      cap = iter_cap;
      if (cap == 0) cap = 1;
      if (cap > ITER_LIMIT) cap = ITER_LIMIT;
      zr = 0;
      zi = 0;
      n = 0;
      escaped = 1'b0;
      while (n < cap && !escaped) begin
        sq_re = clamp_q(qmul(zr, zr) - qmul(zi, zi));
        sq_im = clamp_q(2 * qmul(zr, zi));
        zr = clamp_q(sq_re + cr);
        zi = clamp_q(sq_im + ci);
        // radius check uses the unsaturated sum
        radius2 = qmul(zr, zr) + qmul(zi, zi);
        escaped = radius2 >= longint'(FOUR);
        n++;
      end
      limit_hit = !escaped;
      return ITER_W'(n);
    endfunction

    function void note_pixel(logic [PIXEL_BITS-1:0] px, logic [PIXEL_BITS-1:0] py);
      want_counts.push_back(escape_count(px, py));
      n_pixels++;
      if (limit_hit) n_at_cap++;
    endfunction

    function void check_count(logic [ITER_W-1:0] got);
      logic [ITER_W-1:0] want;
      if (want_counts.size() == 0) begin
        $display("%0t: count transaction %0d with no pixel outstanding", $time, got);
        n_errors++;
      end else begin
        want = want_counts.pop_front();
        n_checked++;
        if (got !== want) begin
          $display("%0t: iter_count mismatch: expected %0d, actual %0d", $time, want, got);
          n_errors++;
        end
      end
    endfunction

    function int unsigned pending();
      return want_counts.size();
    endfunction
  endclass

endpackage

>>> dv/mandelbrot_escape_time_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_top_test
// Self-checking bench for the escape-time counter.
// Programs a series of view windows and limits while the block is idle,
// sends directed corner pixels and then random pixels with random source
// gaps and sink stalls, and checks each count in order against a predictor.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_top_test;
  import met_pkg::*;
  import met_escape_tb_pkg::*;

  localparam longint ONE_Q = longint'(1) << FRAC_BITS;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [COORD_W-1:0]   cfg_wdata_i;

  bit              gaps_on = 1'b1;
  int unsigned     n_settings = 1;
  count_scoreboard sb = new();

  met_pix_if pix_ch();
  met_res_if res_ch();

  mandelbrot_escape_time_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_i       (pix_ch),
    .res_o       (res_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // two full-limit points dominate the run, well under this bound
  initial begin
    #15ms;
    $display("Verification failed");
    $finish;
  end

  // sink side: bursts of ready with random stall bursts
  initial begin
    res_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (gaps_on && $urandom_range(0, 3) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end else begin
        res_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) sb.check_count(res_ch.iter_count);
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    sb.set_reg(idx, value);
    @(posedge clk_i);
  endtask

  task automatic program_window(input longint re0, input longint re_step,
                                input longint im0, input longint im_step,
                                input longint cap);
    write_reg(REG_RE_ORIGIN, COORD_W'(re0));
    write_reg(REG_REAL_STEP, COORD_W'(re_step));
    write_reg(REG_IM_ORIGIN, COORD_W'(im0));
    write_reg(REG_IMAG_STEP, COORD_W'(im_step));
    write_reg(REG_MAX_ITER, COORD_W'(cap));
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // valid stays up across back-to-back transactions
  task automatic send_pixel(input logic [PIXEL_BITS-1:0] px, input logic [PIXEL_BITS-1:0] py);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      pix_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    pix_ch.valid   <= 1'b1;
    pix_ch.pixel_x <= px;
    pix_ch.pixel_y <= py;
    do @(posedge clk_i); while (!pix_ch.ready);
    sb.note_pixel(px, py);
  endtask

  task automatic drain_counts();
    pix_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [PIXEL_BITS-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return PIXEL_BITS'($urandom);
    endcase
  endfunction

  task automatic random_pixels(input int unsigned n);
    repeat (n) send_pixel(rand_pixel(), rand_pixel());
    drain_counts();
  endtask

  function automatic longint jitter(input int unsigned span);
    return longint'($urandom_range(0, 2 * span)) - longint'(span);
  endfunction

  initial begin
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= REG_RE_ORIGIN;
    cfg_wdata_i    <= '0;
    pix_ch.valid   <= 1'b0;
    pix_ch.pixel_x <= '0;
    pix_ch.pixel_y <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // writes to unused indexes must leave the reset window alone
    for (int i = REG_MAX_ITER + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), $urandom);
    cfg_we_i <= 1'b0;

    // reset window from -2 at 1/256 per pixel, c saturating just below 8; origin runs the full limit
    send_pixel(12'd512, 12'd512);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd1023, 12'd1023);
    drain_counts();

    // limit of zero behaves as one
    program_window(-2 * ONE_Q, ONE_Q >>> 10, -2 * ONE_Q, ONE_Q >>> 10, 0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd2048, 12'd2048);
    send_pixel(12'd4095, 12'd4095);
    drain_counts();

    // extreme origin and steps, c reaches the lower rail and saturates at the upper
    program_window(longint'(COORD_MIN), 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 1);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd2, 12'd1);
    drain_counts();

    // limit above the ceiling clamps; c = 2 lands exactly on radius 2
    program_window(0, ONE_Q, 0, ONE_Q, 32'h0001_FFFF);
    send_pixel(12'd1, 12'd0);
    send_pixel(12'd2, 12'd0);
    send_pixel(12'd1, 12'd1);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd0, 12'd0);
    drain_counts();

    // whole set in view
    program_window(-5 * ONE_Q / 2 + jitter(1 << 21), 229376 + jitter(4096),
                   -3 * ONE_Q / 2 + jitter(1 << 21), 196608 + jitter(4096),
                   $urandom_range(2, 200));
    random_pixels(20);

    // zoom onto the boundary, where counts spread out
    program_window(-3 * ONE_Q / 4 + jitter(1 << 23), $urandom_range(1, 4096),
                   ONE_Q / 10 + jitter(1 << 23), $urandom_range(1, 4096),
                   $urandom_range(50, 256));
    random_pixels(20);

    // arbitrary register contents, garbage above the used bits
    program_window(longint'($urandom), longint'($urandom), longint'($urandom),
                   longint'($urandom),
                   (longint'($urandom_range(0, 32767)) << ITER_W) | $urandom_range(0, 64));
    random_pixels(20);

    // closing stretch at full rate on both sides
    gaps_on = 1'b0;
    program_window(-5 * ONE_Q / 2 + jitter(1 << 21), 229376 + jitter(4096),
                   -3 * ONE_Q / 2 + jitter(1 << 21), 196608 + jitter(4096),
                   $urandom_range(1, 128));
    random_pixels(20);

    $display("Covered %0d pixel transactions over %0d window settings, %0d counts checked",
             sb.n_pixels, n_settings, sb.n_checked);
    $display("%0d points reached the iteration limit, the others escaped", sb.n_at_cap);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
